[hdl/msig_pkg.sv]
// ---------------------------------------------------------------------------
// msig_pkg: shared types and constants of the masked signature scanner
// Register indexes, reset values, hash constants and the command/status
// structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package msig_pkg;

  // window length default
  localparam int WINDOW_BYTES_DEF = 32;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 2'd2;

  // register reset values
  localparam logic [WORD_W-1:0] SIGNATURE_RST = 32'h0000_0000;
  localparam logic [WORD_W-1:0] BYTE_MASK_RST = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] HASH_SEED_RST = 32'd5381;

  // hash multiplier 33 is a shift by five plus one
  localparam int HASH_SHIFT = 5;

  // saturated byte count
  localparam logic [WORD_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the input word into the window
    logic step;    // one hash iteration
    logic finish;  // close the current word
    logic emit;    // write the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic check_needed;   // accepted byte completes a window to hash
    logic load_last;      // accepted byte ends the region
    logic hash_last;      // final hash iteration this cycle
    logic result_needed;  // finishing word gives a result
  } dp_status_t;

endpackage

[hdl/msig_if.sv]
// ---------------------------------------------------------------------------
// msig_in_if / msig_out_if: valid/ready channels of the scanner
// Input carries region bytes, output carries scan results.
// ---------------------------------------------------------------------------
interface msig_in_if;
  logic                         valid;
  logic                         ready;
  logic [msig_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msig_out_if;
  logic                         valid;
  logic                         ready;
  logic                         match_found;
  logic [msig_pkg::WORD_W-1:0]  match_offset;
  logic                         region_done;

  modport source (output valid, output match_found, output match_offset,
                  output region_done, input ready);
  modport sink   (input valid, input match_found, input match_offset,
                  input region_done, output ready);
endinterface

[hdl/masked_hash_signature_scanner.sv]
// ---------------------------------------------------------------------------
// masked_hash_signature_scanner: first masked-hash window match in a region
// Each byte is shifted into a window; when a full window lies in the region
// its masked djb2a-style hash is compared with the signature.
// ---------------------------------------------------------------------------
// throughput: one byte per cycle while bytes are neither hashed nor last; a last byte
//   with no window to hash goes through FINISH, and one that completes a window through
//   HASH (one shared shift-add-xor iteration per window byte) then FINISH; no byte is
//   taken outside IDLE. latency: the result word is registered when FINISH emits it;
//   finish waits while a result is due and out is full
// reset: synchronous, clears region state, loads register defaults
module masked_hash_signature_scanner #(
  parameter int WINDOW_BYTES = msig_pkg::WINDOW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [msig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msig_pkg::WORD_W-1:0]     cfg_data,
  msig_in_if.sink                         in_ch,
  msig_out_if.source                      out_ch
);

  msig_pkg::ctrl_cmd_t  cmd;
  msig_pkg::dp_status_t status;

  // sequencer
  msig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  msig_dp #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (in_ch.data_byte),
    .last_byte    (in_ch.last_byte),
    .cmd          (cmd),
    .status       (status),
    .match_found  (out_ch.match_found),
    .match_offset (out_ch.match_offset)
  );

  // region_done is driven high on every result word, also on a match before the last byte
  assign out_ch.region_done = 1'b1;

endmodule

[hdl/msig_ctrl.sv]
// ---------------------------------------------------------------------------
// msig_ctrl: scanner sequencer
// Takes one byte, runs the hash iterations when a window is due, and after a
// hashed or last byte closes the word and hands any result to the output register.
// ---------------------------------------------------------------------------
module msig_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  msig_pkg::dp_status_t  status,
  output msig_pkg::ctrl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_HASH   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.check_needed) begin
            state_next = ST_HASH;
          end else if (status.load_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_HASH: begin
        cmd.step = 1'b1;
        if (status.hash_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.result_needed || slot_free) begin
          cmd.finish = 1'b1;
          cmd.emit   = status.result_needed;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output word valid
  always_comb begin
    priority if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hdl/msig_dp.sv]
// ---------------------------------------------------------------------------
// msig_dp: scanner datapath
// Configuration registers, byte window, region count, shared
// shift-add-xor hash unit, signature compare and result register.
// ---------------------------------------------------------------------------
module msig_dp #(
  parameter int WINDOW_BYTES = msig_pkg::WINDOW_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [msig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msig_pkg::WORD_W-1:0]     cfg_data,
  input  logic [msig_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            last_byte,
  input  msig_pkg::ctrl_cmd_t             cmd,
  output msig_pkg::dp_status_t            status,
  output logic                            match_found,
  output logic [msig_pkg::WORD_W-1:0]     match_offset
);

  localparam int IDX_W = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
  localparam logic [IDX_W-1:0] K_LAST = IDX_W'(WINDOW_BYTES - 1);
  localparam logic [msig_pkg::WORD_W-1:0] WIN_LEN = msig_pkg::WORD_W'(WINDOW_BYTES);

  logic [msig_pkg::WORD_W-1:0] signature_value;
  logic [msig_pkg::WORD_W-1:0] byte_mask;
  logic [msig_pkg::WORD_W-1:0] hash_seed;

  logic [msig_pkg::BYTE_W-1:0] window_bytes [WINDOW_BYTES];
  logic [msig_pkg::WORD_W-1:0] byte_count;
  logic [msig_pkg::WORD_W-1:0] byte_count_next;
  logic                        already_found;
  logic                        counted;

  logic [msig_pkg::WORD_W-1:0] hash;
  logic [msig_pkg::WORD_W-1:0] hash_next;
  logic [IDX_W-1:0]            k;
  logic [msig_pkg::BYTE_W-1:0] masked_byte;

  logic checked;
  logic last_flag;
  logic match;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      signature_value <= msig_pkg::SIGNATURE_RST;
      byte_mask       <= msig_pkg::BYTE_MASK_RST;
      hash_seed       <= msig_pkg::HASH_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msig_pkg::REG_SIGNATURE: signature_value <= cfg_data;
        msig_pkg::REG_BYTE_MASK: byte_mask       <= cfg_data;
        msig_pkg::REG_HASH_SEED: hash_seed       <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating count and window check decision
  assign counted         = (byte_count != msig_pkg::COUNT_MAX);
  assign byte_count_next = counted ? byte_count + 32'd1 : byte_count;

  assign status.check_needed  = !already_found && counted && (byte_count_next >= WIN_LEN);
  assign status.load_last     = last_byte;
  assign status.hash_last     = (k == K_LAST);
  assign status.result_needed = match || (last_flag && !already_found);

  // one hash iteration: hash*33 xor masked byte
  assign masked_byte = byte_mask[k] ? window_bytes[k] : '0;
  assign hash_next   = ((hash << msig_pkg::HASH_SHIFT) + hash)
                       ^ {{(msig_pkg::WORD_W-msig_pkg::BYTE_W){1'b0}}, masked_byte};

  assign match = checked && (hash == signature_value);

  // window shift, newest byte at the top
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        window_bytes[i] <= window_bytes[i+1];
      end
      window_bytes[WINDOW_BYTES-1] <= data_byte;
    end
  end

  // region state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      already_found <= 1'b0;
      checked       <= 1'b0;
      last_flag     <= 1'b0;
    end else if (cmd.load) begin
      byte_count <= byte_count_next;
      checked    <= status.check_needed;
      last_flag  <= last_byte;
    end else if (cmd.finish) begin
      checked   <= 1'b0;
      last_flag <= 1'b0;
      if (last_flag) begin
        byte_count    <= '0;
        already_found <= 1'b0;
      end else if (match) begin
        already_found <= 1'b1;
      end
    end
  end

  // shared hash unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hash <= hash_seed;
      k    <= '0;
    end else if (cmd.step) begin
      hash <= hash_next;
      k    <= k + IDX_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      match_found  <= match;
      match_offset <= match ? (byte_count - WIN_LEN) : '0;
    end
  end

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: regression bench of the masked hash signature scanner
// Feeds byte regions with random valid/ready gaps on both channels.
// Regions carry planted signature windows so that matches, including one on
// the last byte, occur often. Each phase after the first writes its own signature,
// mask and seed. A scoreboard compares every result word with a local scan model.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int WIN          = msig_pkg::WINDOW_BYTES_DEF;
  localparam int DRAIN_CYCLES = 3 * (WIN + 2);
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 9;
  localparam int PHASE_BYTES  = 105;

  typedef struct packed {
    logic [msig_pkg::BYTE_W-1:0] data;
    logic                        last;
  } region_byte_t;

  typedef struct packed {
    logic                        found;
    logic [msig_pkg::WORD_W-1:0] offset;
    logic                        done;
  } scan_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [msig_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [msig_pkg::WORD_W-1:0]    cfg_data;

  msig_in_if  in_ch ();
  msig_out_if out_ch ();

  masked_hash_signature_scanner u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // pending bytes and expected result words
  region_byte_t byte_q[$];
  scan_result_t result_q[$];

  // scan model state and register copies
  logic [8*WIN-1:0]            scan_win;
  logic [msig_pkg::WORD_W-1:0] scan_count;
  logic                        scan_hit;
  logic [msig_pkg::WORD_W-1:0] sig_reg;
  logic [msig_pkg::WORD_W-1:0] mask_reg;
  logic [msig_pkg::WORD_W-1:0] seed_reg;
  logic [8*WIN-1:0]            sig_pattern;

  int  bytes_queued;
  int  bytes_taken;
  int  regions_closed;
  int  hits;
  int  misses;
  int  err_count;
  int  cycle_count;
  int  send_hold;
  int  recv_hold;
  bit  idle_on;
  region_byte_t next_word;
  scan_result_t want;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // masked multiply-by-33 xor hash over one window
  function automatic logic [msig_pkg::WORD_W-1:0] masked_digest(
      input logic [8*WIN-1:0] w,
      input logic [msig_pkg::WORD_W-1:0] mask,
      input logic [msig_pkg::WORD_W-1:0] seed);
    logic [msig_pkg::WORD_W-1:0] h;
    logic [msig_pkg::BYTE_W-1:0] b;
    int k;
    h = seed;
    for (k = 0; k < WIN; k++) begin
      b = mask[k] ? w[8*k +: 8] : 8'h00;
      h = (h * 33) ^ {24'h0, b};
    end
    return h;
  endfunction

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic [msig_pkg::BYTE_W-1:0] data, input logic last);
    byte_q.push_back('{data: data, last: last});
    bytes_queued++;
  endtask

  // one region of random bytes, optionally with the signature window at plant_at
  task automatic queue_region(input int len, input int plant_at);
    logic [msig_pkg::BYTE_W-1:0] b;
    int i;
    for (i = 0; i < len; i++) begin
      b = msig_pkg::BYTE_W'($urandom_range(0, 255));
      if (plant_at >= 0 && i >= plant_at && i < plant_at + WIN && mask_reg[i - plant_at])
        b = sig_pattern[8*(i - plant_at) +: 8];
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [msig_pkg::CFG_IDX_W-1:0] idx,
                           input logic [msig_pkg::WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      msig_pkg::REG_SIGNATURE: sig_reg  = value;
      msig_pkg::REG_BYTE_MASK: mask_reg = value;
      msig_pkg::REG_HASH_SEED: seed_reg = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every byte is taken and every result word has come
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // byte driver and scan model
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_hold = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        scan_win = {in_ch.data_byte, scan_win[8*WIN-1:8]};
        if (scan_count != msig_pkg::COUNT_MAX) begin
          scan_count++;
          if (!scan_hit && scan_count >= WIN &&
              masked_digest(scan_win, mask_reg, seed_reg) == sig_reg) begin
            scan_hit = 1'b1;
            hits++;
            result_q.push_back('{found: 1'b1, offset: scan_count - WIN, done: 1'b1});
          end
        end
        // region end: not-found word unless a match was already reported
        if (in_ch.last_byte) begin
          if (!scan_hit) begin
            misses++;
            result_q.push_back('{found: 1'b0, offset: '0, done: 1'b1});
          end
          regions_closed++;
          scan_win   = '0;
          scan_count = '0;
          scan_hit   = 1'b0;
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_hold > 0) begin
          send_hold--;
          in_ch.valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          next_word = byte_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= next_word.data;
          in_ch.last_byte <= next_word.last;
          send_hold = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and scoreboard
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result word with no expectation: match_found=%0b match_offset=%0d",
                 out_ch.match_found, out_ch.match_offset);
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.match_found !== want.found) begin
            $error("match_found: expected %0b, got %0b", want.found, out_ch.match_found);
            err_count++;
          end
          if (out_ch.match_offset !== want.offset) begin
            $error("match_offset: expected %0d, got %0d", want.offset, out_ch.match_offset);
            err_count++;
          end
          if (out_ch.region_done !== want.done) begin
            $error("region_done: expected %0b, got %0b", want.done, out_ch.region_done);
            err_count++;
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_hold = pick_gap();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words outstanding",
               cycle_count, result_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int ph;
    int n;
    int len;
    int plant_at;
    int r;
    int k;
    bit plant;
    logic [msig_pkg::WORD_W-1:0] new_mask;
    logic [msig_pkg::WORD_W-1:0] new_seed;
    logic [msig_pkg::WORD_W-1:0] new_sig;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = msig_pkg::REG_SIGNATURE;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    scan_win        = '0;
    scan_count      = '0;
    scan_hit        = 1'b0;
    sig_reg         = msig_pkg::SIGNATURE_RST;
    mask_reg        = msig_pkg::BYTE_MASK_RST;
    seed_reg        = msig_pkg::HASH_SEED_RST;
    sig_pattern     = '0;
    bytes_queued    = 0;
    bytes_taken     = 0;
    regions_closed  = 0;
    hits            = 0;
    misses          = 0;
    err_count       = 0;
    cycle_count     = 0;
    idle_on         = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: regions shorter than a window under reset registers
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b1);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      idle_on = (ph % 3 != 2);
      plant   = (ph != 0 && ph != 4);

      // new signature window and register setting for this phase
      if (ph != 0) begin
        for (k = 0; k < WIN / 4; k++) sig_pattern[32*k +: 32] = $urandom;
        case (ph)
          1: begin new_mask = 32'hFFFF_FFFF; new_seed = $urandom; end
          2: begin new_mask = 32'h0000_0000; new_seed = 32'h0000_0000; end
          3: begin new_mask = $urandom; new_seed = 32'hFFFF_FFFF; end
          4: begin new_mask = 32'h0000_0000; new_seed = $urandom; end
          5: begin new_mask = 32'h8000_0001; new_seed = msig_pkg::HASH_SEED_RST; end
          6: begin new_mask = $urandom & $urandom & $urandom; new_seed = 32'h0000_0000; end
          7: begin new_mask = 32'hFFFF_FFFF; new_seed = msig_pkg::HASH_SEED_RST; end
          default: begin new_mask = $urandom; new_seed = $urandom; end
        endcase
        new_sig = (ph == 4) ? 32'hFFFF_FFFF : masked_digest(sig_pattern, new_mask, new_seed);
        write_reg(msig_pkg::REG_BYTE_MASK, new_mask);
        write_reg(msig_pkg::REG_HASH_SEED, new_seed);
        write_reg(msig_pkg::REG_SIGNATURE, new_sig);
      end

      // random regions, some of them with the signature window planted
      n = 0;
      while (n < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 15) len = $urandom_range(1, WIN - 1);
        else if (r < 30) len = WIN;
        else if (r < 92) len = $urandom_range(WIN + 1, 90);
        else len = $urandom_range(100, 250);
        plant_at = -1;
        if (plant && len >= WIN && $urandom_range(0, 99) < 65)
          plant_at = ($urandom_range(0, 99) < 30) ? len - WIN : $urandom_range(0, len - WIN);
        queue_region(len, plant_at);
        n += len;
      end
    end

    wait_idle();
    $display("scanned %0d bytes in %0d regions over %0d register settings",
             bytes_taken, regions_closed, PHASES);
    $display("signature hits: %0d, regions without a hit: %0d", hits, misses);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
